// ----- design/sidasc_pkg.sv -----
package sidasc_pkg;

  // Field widths.
  localparam int unsigned ValW   = 32;
  localparam int unsigned CharW  = 8;

  // Decimal layout: ten digits cover every 32-bit magnitude.
  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned BcdW      = NumDigits * DigitW;
  localparam int unsigned DigIdxW   = $clog2(NumDigits);

  // Shift-and-add-3 conversion, cut into equal pipeline stages.
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned NumDabStages  = ValW / StepsPerStage;

  // Character codes.
  localparam logic [CharW-1:0] AsciiZero  = 8'd48;
  localparam logic [CharW-1:0] AsciiMinus = 8'd45;

  // Payload of one conversion stage.
  typedef struct packed {
    logic            neg;
    logic [BcdW-1:0] bcd;
    logic [ValW-1:0] bin;
  } dab_t;

endpackage

// ----- design/sidasc_dabble.sv -----
module sidasc_dabble (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  sidasc_pkg::dab_t   data_i,
  output logic               valid_o,
  output sidasc_pkg::dab_t   data_o
);

  logic             valid_q;
  sidasc_pkg::dab_t data_q;
  sidasc_pkg::dab_t data_d;

  // Several shift-and-add-3 steps: correct every digit of five or more, then
  // shift the next binary bit into the decimal word.
  always_comb begin
    logic [sidasc_pkg::BcdW-1:0] bcd;
    logic [sidasc_pkg::ValW-1:0] bin;
    bcd = data_i.bcd;
    bin = data_i.bin;
    for (int s = 0; s < sidasc_pkg::StepsPerStage; s++) begin
      for (int d = 0; d < sidasc_pkg::NumDigits; d++) begin
        if (bcd[d*sidasc_pkg::DigitW +: sidasc_pkg::DigitW] >= 4'd5) begin
          bcd[d*sidasc_pkg::DigitW +: sidasc_pkg::DigitW] =
            bcd[d*sidasc_pkg::DigitW +: sidasc_pkg::DigitW] + 4'd3;
        end
      end
      bcd = {bcd[sidasc_pkg::BcdW-2:0], bin[sidasc_pkg::ValW-1]};
      bin = {bin[sidasc_pkg::ValW-2:0], 1'b0};
    end
    data_d.neg = data_i.neg;
    data_d.bcd = bcd;
    data_d.bin = bin;
  end

  // Valid bit follows the data when the pipeline moves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- design/signed_int_to_decimal_ascii_core.sv -----
// Converts one signed 32-bit value per beat into its decimal ASCII text, one
// character per output cycle on strobe_o, with last_char_o on the final digit.
// A number of 1 to 11 characters goes out on consecutive strobes, and the
// single character serializer at the end sets the sustained rate; busy_o is
// high while the pipeline is held behind it. With the serializer idle, a value
// runs through the input, magnitude, conversion, digit-count, serializer and
// output registers. The receiver cannot stall: every strobe is a delivered beat.
module signed_int_to_decimal_ascii_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [sidasc_pkg::ValW-1:0] value_i,
  output logic                               strobe_o,
  output logic [sidasc_pkg::CharW-1:0]       ascii_char_o,
  output logic                               last_char_o
);

  localparam int unsigned NumDab = sidasc_pkg::NumDabStages;

  logic adv;
  logic ser_free;

  // Input capture stage.
  logic                        in_vld_q;
  logic [sidasc_pkg::ValW-1:0] in_raw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_raw_q <= value_i;
    end
  end

  // Magnitude stage: two's complement negation gives the unsigned magnitude,
  // which also covers the most negative value.
  logic             mag_vld_q;
  sidasc_pkg::dab_t mag_q;
  sidasc_pkg::dab_t mag_d;

  always_comb begin
    mag_d.neg = in_raw_q[sidasc_pkg::ValW-1];
    mag_d.bcd = '0;
    mag_d.bin = in_raw_q[sidasc_pkg::ValW-1] ? (~in_raw_q + 1'b1) : in_raw_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_vld_q <= 1'b0;
    end else if (adv) begin
      mag_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q <= mag_d;
    end
  end

  // Binary to BCD conversion stages.
  logic             dab_vld [NumDab+1];
  sidasc_pkg::dab_t dab     [NumDab+1];

  assign dab_vld[0] = mag_vld_q;
  assign dab[0]     = mag_q;

  for (genvar g = 0; g < NumDab; g++) begin : g_dab
    sidasc_dabble u_dab (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (dab_vld[g]),
      .data_i  (dab[g]),
      .valid_o (dab_vld[g+1]),
      .data_o  (dab[g+1])
    );
  end

  // Digit count stage: find the most significant nonzero digit.
  logic                           cnt_vld_q;
  logic                           cnt_neg_q;
  logic [sidasc_pkg::BcdW-1:0]    cnt_bcd_q;
  logic [sidasc_pkg::DigIdxW-1:0] cnt_top_q;
  logic [sidasc_pkg::DigIdxW-1:0] cnt_top_d;

  always_comb begin
    cnt_top_d = '0;
    for (int d = 0; d < sidasc_pkg::NumDigits; d++) begin
      if (dab[NumDab].bcd[d*sidasc_pkg::DigitW +: sidasc_pkg::DigitW] != '0) begin
        cnt_top_d = sidasc_pkg::DigIdxW'(d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= 1'b0;
    end else if (adv) begin
      cnt_vld_q <= dab_vld[NumDab];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cnt_neg_q <= dab[NumDab].neg;
      cnt_bcd_q <= dab[NumDab].bcd;
      cnt_top_q <= cnt_top_d;
    end
  end

  // Character serializer: a pending sign first, then digits from the top down.
  logic                           act_q;
  logic                           negp_q;
  logic [sidasc_pkg::DigIdxW-1:0] idx_q;
  logic [sidasc_pkg::DigitW-1:0]  dig_q [sidasc_pkg::NumDigits];
  logic                           load;

  assign ser_free = !act_q || (!negp_q && (idx_q == '0));
  assign adv      = !cnt_vld_q || ser_free;
  assign load     = adv && cnt_vld_q;
  assign busy_o   = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      negp_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      act_q  <= 1'b1;
      negp_q <= cnt_neg_q;
      idx_q  <= cnt_top_q;
    end else if (act_q) begin
      if (negp_q) begin
        negp_q <= 1'b0;
      end else if (idx_q == '0) begin
        act_q <= 1'b0;
      end else begin
        idx_q <= idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int d = 0; d < sidasc_pkg::NumDigits; d++) begin
        dig_q[d] <= cnt_bcd_q[d*sidasc_pkg::DigitW +: sidasc_pkg::DigitW];
      end
    end
  end

  // Output register: one beat per serializer cycle.
  logic                         strobe_q;
  logic [sidasc_pkg::CharW-1:0] char_q;
  logic [sidasc_pkg::CharW-1:0] char_d;
  logic                         last_q;

  assign char_d = negp_q ? sidasc_pkg::AsciiMinus
                         : sidasc_pkg::AsciiZero
                           + sidasc_pkg::CharW'(dig_q[idx_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= !negp_q && (idx_q == '0);
  end

  assign strobe_o     = strobe_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

endmodule

// ----- tb/sv/signed_int_to_decimal_ascii_core_test.sv -----
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_core_test;

  localparam int unsigned RandomNumbers = 500;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned DrainCycles   = 30;
  localparam int unsigned MaxPrinted    = 30;

  // One expected character of the decimal text.
  typedef struct {
    logic [sidasc_pkg::CharW-1:0] ch;
    logic                         last;
  } text_char_t;

  // One directed number; an empty text means the predictor supplies it.
  typedef struct {
    logic signed [sidasc_pkg::ValW-1:0] value;
    string                              text;
  } number_row_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               start_i;
  logic                               busy_o;
  logic signed [sidasc_pkg::ValW-1:0] value_i;
  logic                               strobe_o;
  logic [sidasc_pkg::CharW-1:0]       ascii_char_o;
  logic                               last_char_o;

  text_char_t  chars_expected[$];
  string       typed_texts[$];
  number_row_t number_rows[];

  int unsigned cycles;
  int unsigned mismatches;
  int unsigned numbers_sent;
  int unsigned negatives_sent;
  int unsigned chars_checked;
  bit          no_idle;
  text_char_t  oldest_char;
  string       beat_text;

  signed_int_to_decimal_ascii_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .value_i      (value_i),
    .strobe_o     (strobe_o),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Works out the decimal text of one 32-bit value: sign, then digits from
  // the most significant one, with last set on the final digit.
  function automatic void predict_text(input logic [sidasc_pkg::ValW-1:0] raw);
    logic [sidasc_pkg::ValW-1:0] mag;
    logic [3:0]                  digits[sidasc_pkg::NumDigits];
    int                          count;
    text_char_t                  item;
    mag   = raw[sidasc_pkg::ValW-1] ? (~raw + 1'b1) : raw;
    count = 0;
    do begin
      digits[count] = 4'(mag % 10);
      mag           = mag / 10;
      count++;
    end while (mag != 0 && count < sidasc_pkg::NumDigits);
    if (raw[sidasc_pkg::ValW-1]) begin
      item.ch   = sidasc_pkg::AsciiMinus;
      item.last = 1'b0;
      chars_expected.push_back(item);
    end
    for (int i = count - 1; i >= 0; i--) begin
      item.ch   = sidasc_pkg::AsciiZero + sidasc_pkg::CharW'(digits[i]);
      item.last = (i == 0);
      chars_expected.push_back(item);
    end
  endfunction

  // Queues a text that was typed in by hand.
  function automatic void expect_typed(input string text);
    text_char_t item;
    for (int i = 0; i < text.len(); i++) begin
      item.ch   = text[i];
      item.last = (i == text.len() - 1);
      chars_expected.push_back(item);
    end
  endfunction

  // Output check and input capture, both sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe_o) begin
        if (chars_expected.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with no number pending",
                                    ascii_char_o));
        end else begin
          oldest_char = chars_expected.pop_front();
          chars_checked++;
          if (ascii_char_o !== oldest_char.ch) begin
            report_mismatch($sformatf("ascii_char got 0x%02h, want 0x%02h",
                                      ascii_char_o, oldest_char.ch));
          end
          if (last_char_o !== oldest_char.last) begin
            report_mismatch($sformatf("last_char got %b, want %b on 0x%02h",
                                      last_char_o, oldest_char.last, oldest_char.ch));
          end
        end
      end
      if (start_i && !busy_o) begin
        beat_text = (typed_texts.size() != 0) ? typed_texts.pop_front() : "";
        if (beat_text.len() != 0) begin
          expect_typed(beat_text);
        end else begin
          predict_text(value_i);
        end
        numbers_sent++;
        if (value_i < 0) begin
          negatives_sent++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d characters outstanding.",
               cycles, chars_expected.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sends one number: an optional gap, then start held until the beat is taken.
  task automatic send_number(input logic signed [sidasc_pkg::ValW-1:0] value,
                             input string text);
    int unsigned gap;
    gap = (!no_idle && $urandom_range(99) < 6) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      start_i = 1'b0;
      value_i = $urandom;
      repeat (gap) @(negedge clk_i);
    end
    typed_texts.push_back(text);
    start_i = 1'b1;
    value_i = value;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Random value with its weight on short numbers, decade edges and extremes.
  function automatic logic signed [sidasc_pkg::ValW-1:0] pick_value();
    logic [sidasc_pkg::ValW-1:0] v;
    logic [sidasc_pkg::ValW-1:0] decade;
    decade = 1;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = sidasc_pkg::ValW'($urandom_range(0, 200)) - 100;
      2: begin
        repeat ($urandom_range(0, 9)) decade = decade * 10;
        v = decade + sidasc_pkg::ValW'($urandom_range(0, 2)) - 1;
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
      3: v = $urandom_range(1)
             ? 32'h8000_0000 + sidasc_pkg::ValW'($urandom_range(0, 20))
             : 32'h7fff_ffff - sidasc_pkg::ValW'($urandom_range(0, 20));
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
    endcase
    return v;
  endfunction

  // Stimulus: directed table, then random numbers, then drain.
  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    value_i = '0;
    no_idle = 1'b0;
    number_rows = '{
      '{32'sd0,           "0"},
      '{32'sd1,           "1"},
      '{-32'sd1,          "-1"},
      '{32'sd9,           "9"},
      '{32'sd10,          "10"},
      '{-32'sd10,         "-10"},
      '{32'sh7fff_ffff,   "2147483647"},
      '{32'sh8000_0000,   "-2147483648"},
      '{32'sh8000_0001,   "-2147483647"},
      '{32'sd1000000000,  "1000000000"},
      '{32'sd999999999,   ""},
      '{-32'sd999999999,  ""},
      '{32'sh5555_5555,   ""},
      '{32'shaaaa_aaaa,   ""},
      '{32'sd100,         ""},
      '{-32'sd99,         ""},
      '{32'sd0,           "0"},
      '{32'sh7fff_ffff,   "2147483647"}
    };
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (number_rows[i]) begin
      send_number(number_rows[i].value, number_rows[i].text);
    end

    // Random part, with a long stretch in the middle sent back to back.
    for (int n = 0; n < RandomNumbers; n++) begin
      no_idle = (n >= 200 && n < 350);
      send_number(pick_value(), "");
    end
    start_i = 1'b0;
    value_i = '0;

    while (chars_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d numbers (%0d negative, both 32-bit extremes included),",
             numbers_sent, negatives_sent);
    $display("checked %0d characters with %0d mismatches.", chars_checked, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
